// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sampler RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/ldts_pkg.sv =====
// Shared types and constants of the loaded-dice tree sampler.
// No dependencies; used by loaded_dice_tree_sampler.
`default_nettype none

package ldts_pkg;

  // request kinds
  localparam logic [1:0] KIND_COUNT   = 2'd0;
  localparam logic [1:0] KIND_OUTCOME = 2'd1;
  localparam logic [1:0] KIND_BIT     = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_OUTCOMES = 1'b0;
  localparam logic REG_NUM_LEVELS   = 1'b1;

  localparam int CFG_W     = 7;
  localparam int VALUE_W   = 7;
  localparam int LEVEL_W   = 6;
  localparam int ROW_W     = 7;
  localparam int POS_W     = 8;
  localparam int DIST_W    = 9;
  localparam int OUTCOME_W = 6;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CFG_W-1:0] NUM_OUTCOMES_RST = 7'd1;
  localparam logic [CFG_W-1:0] NUM_LEVELS_RST   = 7'd1;

  // request waiting on the outcome table read data
  typedef struct packed {
    logic valid;
    logic single;  // single-outcome mode, result is outcome 0
    logic rd;      // result comes from the outcome table
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/loaded_dice_tree_sampler.sv =====
// Loaded-dice tree sampler: walks a generating tree one random bit per request.
// Depends on ldts_pkg, ldts_ram and assert_macros.svh.
//
// Use: software writes num_outcomes and num_levels over the APB port, then
// loads the per-level leaf counts (kind 0) and the outcome labels (kind 1)
// as requests on the in_ channel. Every kind 2 request carries one random
// bit; with one outcome it gives outcome 0, else it moves the walk one level:
// a leaf with a real outcome produces one request on the out_ channel, a reject
// leaf or a walk past the depth produces none. Any table or register write
// restarts the walk. A result goes through the result stage (s2_r and the
// label read data), then the out_ register. Throughput: one request per cycle
// while in_stall is low. The walk state sits in registers, the leaf count of
// the current level is prefetched from its RAM every cycle, and the outcome
// label is read into the result stage. Stall: while out_stall holds a pending
// result and another result is waiting on its table read, in_stall is raised;
// nothing is dropped. Reset: registers return to one outcome, one level, walk
// at the root. Both tables are undefined after reset until written; there is
// no clearing pass, so requests are taken from the first cycle after reset.
`default_nettype none

`include "assert_macros.svh"

module loaded_dice_tree_sampler #(
  parameter int MAX_OUTCOMES = 64,
  parameter int MAX_LEVELS   = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [1:0]                        in_kind,
  input  wire logic [ldts_pkg::LEVEL_W-1:0]      in_level,
  input  wire logic [ldts_pkg::ROW_W-1:0]        in_row,
  input  wire logic [ldts_pkg::VALUE_W-1:0]      in_value,
  input  wire logic                              in_random_bit,
  // result channel
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [ldts_pkg::OUTCOME_W-1:0]    out_outcome,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ldts_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [ldts_pkg::PDATA_W-1:0]      pwdata,
  output      logic [ldts_pkg::PDATA_W-1:0]      prdata,
  output      logic                              pready
);

  localparam int LW       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int NW       = $clog2(MAX_OUTCOMES + 1);
  localparam int KW       = $clog2(MAX_LEVELS + 1);
  localparam int OT_DEPTH = (MAX_OUTCOMES + 1) * MAX_LEVELS;
  localparam int OAW      = (OT_DEPTH > 1) ? $clog2(OT_DEPTH) : 1;

  localparam int VW = ldts_pkg::VALUE_W;
  localparam int DW = ldts_pkg::DIST_W;
  localparam int PW = ldts_pkg::POS_W;

  // configuration registers
  logic [ldts_pkg::CFG_W-1:0] num_outcomes_r, num_outcomes_nxt;
  logic [ldts_pkg::CFG_W-1:0] num_levels_r, num_levels_nxt;
  logic                       cfg_we;

  // walk state
  logic [LW-1:0] level_r, level_nxt;
  logic [PW-1:0] position_r, position_nxt;

  // count RAM forwarding
  logic          cnt_fwd_r, cnt_fwd_nxt;
  logic [VW-1:0] cnt_fwd_data_r;

  ldts_pkg::stage_t s2_r, s2_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [ldts_pkg::OUTCOME_W-1:0]     out_outcome_r, out_outcome_nxt;

  logic [NW-1:0] n_eff;
  logic [KW-1:0] k_eff;
  logic          n_single;

  logic          accept;
  logic          s2_adv;
  logic          s2_emit;
  logic          lvl_ok;
  logic          row_ok_w;
  logic [DW-1:0] walk_dist;
  logic [DW-1:0] rem;
  logic [PW-1:0] rem_sat;
  logic [VW-1:0] leaf_cnt;
  logic          hit;
  logic          row_ok;
  logic          last_level;

  logic          cnt_we;
  logic [LW-1:0] cnt_waddr;
  logic [VW-1:0] cnt_rdata;

  logic           ot_we;
  logic [OAW-1:0] ot_waddr;
  logic           ot_re;
  logic [OAW-1:0] ot_raddr;
  logic [VW-1:0]  ot_rdata;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    num_outcomes_nxt = num_outcomes_r;
    num_levels_nxt   = num_levels_r;
    if (cfg_we) begin
      unique case (paddr[2])
        ldts_pkg::REG_NUM_OUTCOMES: num_outcomes_nxt = pwdata[ldts_pkg::CFG_W-1:0];
        ldts_pkg::REG_NUM_LEVELS:   num_levels_nxt   = pwdata[ldts_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ldts_pkg::REG_NUM_OUTCOMES: prdata = ldts_pkg::PDATA_W'(num_outcomes_r);
      ldts_pkg::REG_NUM_LEVELS:   prdata = ldts_pkg::PDATA_W'(num_levels_r);
      default:                    prdata = '0;
    endcase
  end

  // clamped outcome count and depth
  always_comb begin
    if (num_outcomes_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_outcomes_r) > MAX_OUTCOMES) begin
      n_eff = NW'(MAX_OUTCOMES);
    end else begin
      n_eff = NW'(num_outcomes_r);
    end
    if (num_levels_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(num_levels_r) > MAX_LEVELS) begin
      k_eff = KW'(MAX_LEVELS);
    end else begin
      k_eff = KW'(num_levels_r);
    end
  end

  assign n_single = (n_eff == NW'(1));

  // ---------------- walk step ----------------
  assign s2_adv   = !out_valid_r || !out_stall;
  assign in_stall = s2_r.valid && !s2_adv;
  assign accept   = in_valid && !in_stall;

  assign lvl_ok   = 32'(in_level) < MAX_LEVELS;
  assign row_ok_w = 32'(in_row) <= MAX_OUTCOMES;

  assign leaf_cnt   = cnt_fwd_r ? cnt_fwd_data_r : cnt_rdata;
  assign walk_dist  = {position_r, 1'b0} + DW'(!in_random_bit);
  assign hit        = walk_dist < DW'(leaf_cnt);
  assign row_ok     = 32'(walk_dist) <= MAX_OUTCOMES;
  assign rem        = walk_dist - DW'(leaf_cnt);
  assign rem_sat    = rem[DW-1] ? '1 : rem[PW-1:0];
  assign last_level = (32'(level_r) + 1) >= 32'(k_eff);

  always_comb begin
    level_nxt    = level_r;
    position_nxt = position_r;
    if (cfg_we) begin
      level_nxt    = '0;
      position_nxt = '0;
    end else if (accept) begin
      unique case (in_kind)
        ldts_pkg::KIND_COUNT, ldts_pkg::KIND_OUTCOME: begin
          level_nxt    = '0;
          position_nxt = '0;
        end
        ldts_pkg::KIND_BIT: begin
          if (!n_single) begin
            if (hit || last_level) begin
              level_nxt    = '0;
              position_nxt = '0;
            end else begin
              level_nxt    = level_r + LW'(1);
              position_nxt = rem_sat;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- leaf count table ----------------
  // Read address follows the next level, so the count is ready when the bit arrives.
  assign cnt_we      = accept && (in_kind == ldts_pkg::KIND_COUNT) && lvl_ok;
  assign cnt_waddr   = LW'(in_level);
  assign cnt_fwd_nxt = cnt_we && (cnt_waddr == level_nxt);

  ldts_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_LEVELS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (in_value),
    .re    (1'b1),
    .raddr (level_nxt),
    .rdata (cnt_rdata)
  );

  // ---------------- outcome table ----------------
  assign ot_we    = accept && (in_kind == ldts_pkg::KIND_OUTCOME) && lvl_ok && row_ok_w;
  assign ot_waddr = OAW'(in_row) * OAW'(MAX_LEVELS) + OAW'(in_level);
  assign ot_re    = accept && (in_kind == ldts_pkg::KIND_BIT) && !n_single && hit && row_ok;
  assign ot_raddr = OAW'(walk_dist) * OAW'(MAX_LEVELS) + OAW'(level_r);

  // read data holds while ot_re is low, so a blocked request keeps its label
  ldts_ram #(
    .WIDTH (VW),
    .DEPTH (OT_DEPTH)
  ) u_ot_ram (
    .clk   (clk),
    .we    (ot_we),
    .waddr (ot_waddr),
    .wdata (in_value),
    .re    (ot_re),
    .raddr (ot_raddr),
    .rdata (ot_rdata)
  );

  // ---------------- result stage ----------------
  always_comb begin
    s2_nxt = s2_r;
    if (accept) begin
      s2_nxt.valid  = (in_kind == ldts_pkg::KIND_BIT) && (n_single || ot_re);
      s2_nxt.single = (in_kind == ldts_pkg::KIND_BIT) && n_single;
      s2_nxt.rd     = ot_re;
    end else if (s2_adv) begin
      s2_nxt = '0;
    end
  end

  // labels at or above the outcome count are rejects
  assign s2_emit = s2_r.valid && (s2_r.single || (32'(ot_rdata) < 32'(n_eff)));

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_outcome_nxt = out_outcome_r;
    if (s2_adv) begin
      out_valid_nxt   = s2_emit;
      out_outcome_nxt = s2_r.single ? '0 : ot_rdata[ldts_pkg::OUTCOME_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_outcomes_r <= ldts_pkg::NUM_OUTCOMES_RST;
      num_levels_r   <= ldts_pkg::NUM_LEVELS_RST;
      level_r        <= '0;
      position_r     <= '0;
      cnt_fwd_r      <= 1'b0;
      s2_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      num_outcomes_r <= num_outcomes_nxt;
      num_levels_r   <= num_levels_nxt;
      level_r        <= level_nxt;
      position_r     <= position_nxt;
      cnt_fwd_r      <= cnt_fwd_nxt;
      s2_r           <= s2_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_fwd_data_r <= in_value;
    out_outcome_r  <= out_outcome_nxt;
  end

  // ---------------- assertions ----------------
  `ASSERT_CLK(a_level_in_depth, KW'(level_r) < k_eff, "walk level at or past depth")
  `ASSERT_CLK(a_single_at_root, !n_single || (level_r == '0), "single-outcome walk left root")
  `ASSERT_CLK(a_stage_kind, !s2_r.valid || $onehot({s2_r.single, s2_r.rd}), "bad result stage")
  `ASSERT_NEXT(a_stage_hold, s2_r.valid && !s2_adv, s2_r.valid && $stable(s2_r), "blocked request lost")

endmodule

`default_nettype wire

// ===== rtl/ldts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module ldts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== tb/ldts_walk_checker.sv =====
// Walk checker for the loaded-dice tree sampler: mirrors registers, tables and
// walk state, predicts each outcome and compares it on the out_ channel.
// Depends on ldts_pkg.
module ldts_walk_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_kind,
  input  logic [ldts_pkg::LEVEL_W-1:0]   in_level,
  input  logic [ldts_pkg::ROW_W-1:0]     in_row,
  input  logic [ldts_pkg::VALUE_W-1:0]   in_value,
  input  logic                           in_random_bit,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ldts_pkg::OUTCOME_W-1:0] out_outcome,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [ldts_pkg::PADDR_W-1:0]   paddr,
  input  logic [ldts_pkg::PDATA_W-1:0]   pwdata,
  output int                             mismatches,
  output int                             pending
);
  import ldts_pkg::*;

  localparam int MAX_OUTCOMES = 64;
  localparam int MAX_LEVELS   = 64;

  logic [CFG_W-1:0]     outcomes_reg;
  logic [CFG_W-1:0]     levels_reg;
  logic [LEVEL_W-1:0]   walk_level;
  logic [POS_W-1:0]     walk_pos;
  logic [VALUE_W-1:0]   leaf_count [MAX_LEVELS];
  logic [VALUE_W-1:0]   leaf_label [MAX_OUTCOMES+1][MAX_LEVELS];
  logic [OUTCOME_W-1:0] expected_outcomes [$];
  logic [OUTCOME_W-1:0] want;

  task automatic restart_walk;
    walk_level = '0;
    walk_pos   = '0;
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  // one accepted request: table write, ignored kind, or one step of the walk
  task automatic apply_request(input logic [1:0] kind, input logic [LEVEL_W-1:0] lvl,
                               input logic [ROW_W-1:0] row, input logic [VALUE_W-1:0] value,
                               input logic rbit);
    int n, depth, lev, walk_d, cnt, lbl;
    logic [OUTCOME_W-1:0] label_out;
    n = int'(outcomes_reg);
    if (n < 1) n = 1;
    if (n > MAX_OUTCOMES) n = MAX_OUTCOMES;
    depth = int'(levels_reg);
    if (depth < 1) depth = 1;
    if (depth > MAX_LEVELS) depth = MAX_LEVELS;
    case (kind)
      KIND_COUNT: begin
        leaf_count[lvl] = value;
        restart_walk();
      end
      KIND_OUTCOME: begin
        if (row <= MAX_OUTCOMES) leaf_label[row][lvl] = value;
        restart_walk();
      end
      KIND_BIT: begin
        if (n == 1) begin
          expected_outcomes.push_back('0);
        end else begin
          lev = int'(walk_level);
          if (lev >= depth) begin
            restart_walk();
            lev = 0;
          end
          walk_d = 2 * int'(walk_pos) + 1 - int'(rbit);
          cnt    = int'(leaf_count[lev]);
          if (walk_d < cnt) begin
            // rows past the table end read as reject
            lbl = (walk_d <= MAX_OUTCOMES) ? int'(leaf_label[walk_d][lev]) : 'hFFFF;
            restart_walk();
            if (lbl < n) begin
              label_out = OUTCOME_W'(lbl);
              expected_outcomes.push_back(label_out);
            end
          end else begin
            walk_d = walk_d - cnt;
            if (walk_d > 255) walk_d = 255;
            if (lev + 1 >= depth) begin
              restart_walk();
            end else begin
              walk_level = LEVEL_W'(lev + 1);
              walk_pos   = POS_W'(walk_d);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      outcomes_reg = NUM_OUTCOMES_RST;
      levels_reg   = NUM_LEVELS_RST;
      mismatches   = 0;
      restart_walk();
      expected_outcomes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          flag_mismatch($sformatf("unexpected outcome %0d, none predicted", out_outcome));
        end else begin
          want = expected_outcomes.pop_front();
          if (out_outcome !== want)
            flag_mismatch($sformatf("outcome mismatch: expected %0d, got %0d",
                                    want, out_outcome));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_NUM_LEVELS) levels_reg = pwdata[CFG_W-1:0];
        else outcomes_reg = pwdata[CFG_W-1:0];
        restart_walk();
      end
      if (in_valid && !in_stall)
        apply_request(in_kind, in_level, in_row, in_value, in_random_bit);
    end
    pending = expected_outcomes.size();
  end

endmodule

// ===== tb/loaded_dice_tree_sampler_tb.sv =====
// Top of the loaded-dice tree sampler testbench: clock, reset, APB and request
// stimulus, and the verdict. Depends on ldts_pkg, loaded_dice_tree_sampler and
// ldts_walk_checker.
module loaded_dice_tree_sampler_tb;
  import ldts_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int PHASE_REQUESTS = 170;
  localparam int NUM_PHASES     = 8;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_kind       = '0;
  logic [LEVEL_W-1:0]   in_level      = '0;
  logic [ROW_W-1:0]     in_row        = '0;
  logic [VALUE_W-1:0]   in_value      = '0;
  logic                 in_random_bit = 1'b0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [PDATA_W-1:0]   pwdata        = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int requests_sent  = 0;
  int cycle_count    = 0;
  // per level: rows 0..n-1 of the outcome table hold a written label
  int rows_loaded [64];

  loaded_dice_tree_sampler dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_level     (in_level),
    .in_row       (in_row),
    .in_value     (in_value),
    .in_random_bit(in_random_bit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_outcome  (out_outcome),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  ldts_walk_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_level     (in_level),
    .in_row       (in_row),
    .in_value     (in_value),
    .in_random_bit(in_random_bit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_outcome  (out_outcome),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial forever #5 clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // valid stays high after acceptance until the next falling edge decides
  task automatic send_request(input logic [1:0] kind, input int lvl, input int row,
                              input int value, input int rbit);
    int lv, rw;
    lv = lvl & 63;
    rw = row & 127;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_level      <= LEVEL_W'(lvl);
    in_row        <= ROW_W'(row);
    in_value      <= VALUE_W'(value);
    in_random_bit <= 1'(rbit);
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (kind == KIND_OUTCOME && rw <= 64 && rows_loaded[lv] == rw) rows_loaded[lv]++;
  endtask

  task automatic send_bit(input int rbit);
    send_request(KIND_BIT, $urandom, $urandom, $urandom, rbit);
  endtask

  // labels for every row a count can reach are loaded before the count
  task automatic write_count(input int lvl, input int cnt);
    int lv, need;
    lv   = lvl & 63;
    need = ((cnt & 127) > 65) ? 65 : (cnt & 127);
    while (rows_loaded[lv] < need)
      send_request(KIND_OUTCOME, lv, rows_loaded[lv], $urandom_range(0, 127), $urandom);
    send_request(KIND_COUNT, lv, $urandom, cnt, $urandom);
  endtask

  task automatic write_register(input logic reg_idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= ($urandom & ~32'h7F) | (value & 32'h7F);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase, lvl, r, m, depth, inner, cnt, lo, bits, pick, label, choice;
    int cfg_n, cfg_k, n_eff, k_eff, phase_start;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset config is a single outcome: every bit gives outcome 0
    send_bit(0);
    send_bit(1);
    send_request(KIND_UNUSED, 63, 127, 127, 1);

    // zero every leaf count, so no walk reads an outcome row before it is loaded
    for (lvl = 0; lvl < 64; lvl++) send_request(KIND_COUNT, lvl, $urandom, 0, $urandom);

    // address and value extremes; row 127 is out of range and dropped
    write_count(63, 127);
    send_request(KIND_OUTCOME, 63, 127, 0, 0);
    send_request(KIND_OUTCOME, 63, 64, 127, 0);

    drain_results();
    write_register(REG_NUM_OUTCOMES, 3);
    write_register(REG_NUM_LEVELS, 4);
    write_count(0, 1);
    write_count(1, 1);
    write_count(2, 0);
    write_count(3, 0);
    send_request(KIND_OUTCOME, 0, 0, 2, 0);
    send_request(KIND_OUTCOME, 1, 0, 3, 0);
    send_bit(1);                                    // leaf at root: outcome 2
    repeat (4) send_bit(0);                         // runs past the last level
    send_bit(0);
    send_bit(1);                                    // label equal to n: reject
    send_bit(0);
    send_request(KIND_OUTCOME, 1, 0, 100, 0);       // mid-walk write restarts
    send_bit(0);
    send_bit(1);                                    // label above n: reject

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      case (phase)
        0: begin cfg_n = 2;   cfg_k = 1;   end
        1: begin cfg_n = 64;  cfg_k = 64;  end
        2: begin cfg_n = 127; cfg_k = 127; end
        3: begin cfg_n = 0;   cfg_k = 0;   end
        4: begin cfg_n = 5;   cfg_k = 12;  end
        5: begin cfg_n = 65;  cfg_k = 3;   end
        6: begin cfg_n = 1;   cfg_k = 64;  end
        default: begin
          cfg_n = $urandom_range(2, 64);
          cfg_k = $urandom_range(1, 64);
        end
      endcase
      write_register(REG_NUM_OUTCOMES, cfg_n);
      write_register(REG_NUM_LEVELS, cfg_k);
      case (phase % 4)
        1: send_idle_pct = 82;
        2: recv_stall_pct = 82;
        3: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
        default: ;
      endcase
      n_eff = (cfg_n < 1) ? 1 : (cfg_n > 64) ? 64 : cfg_n;
      k_eff = (cfg_k < 1) ? 1 : (cfg_k > 64) ? 64 : cfg_k;

      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_REQUESTS) begin
        choice = $urandom_range(99);
        if (choice < 70) begin
          // proper tree: at most 4 internal nodes per level, last level all leaves;
          // depth may exceed the configured depth by one
          depth = $urandom_range(1, (k_eff < 8) ? k_eff + 1 : 8);
          inner = 1;
          for (lvl = 0; lvl < depth && inner > 0; lvl++) begin
            lo  = (2 * inner > 4) ? 2 * inner - 4 : 0;
            cnt = (lvl == depth - 1) ? 2 * inner : $urandom_range(lo, 2 * inner);
            for (r = 0; r < cnt; r++) begin
              pick  = $urandom_range(99);
              label = (pick < 85) ? $urandom_range(0, n_eff - 1) :
                      (pick < 93) ? n_eff : $urandom_range(n_eff, 127);
              send_request(KIND_OUTCOME, lvl, r, label, $urandom);
            end
            write_count(lvl, cnt);
            inner = 2 * inner - cnt;
          end
          bits = $urandom_range(20, 60);
          repeat (bits) begin
            if ($urandom_range(99) < 3)
              send_request(KIND_OUTCOME, $urandom, $urandom, $urandom, $urandom);
            else
              send_bit($urandom);
          end
        end else if (choice < 85) begin
          // empty levels push the position up: wide rows, saturation, depth end
          m = $urandom_range(0, 12);
          for (lvl = 0; lvl < m; lvl++) write_count(lvl, 0);
          write_count(m, $urandom_range(64, 127));
          repeat (m + 1 + $urandom_range(0, 4)) send_bit($urandom);
        end else begin
          case ($urandom_range(3))
            0: send_request(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
            1: write_count($urandom_range(0, 63), $urandom_range(0, 127));
            2: send_request(KIND_OUTCOME, $urandom, $urandom, $urandom, $urandom);
            default: send_bit($urandom);
          endcase
        end
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
